@@ rtl/core/bss_pkg.sv @@
// Shared constants and helpers for the bit sequence search block.
// No dependencies; used by bss_match and bit_sequence_search.

package bss_pkg;

    localparam int MAX_PATTERN_BITS = 64;
    localparam int HIST_BITS        = 64;
    localparam int LIMIT_BITS       = (MAX_PATTERN_BITS < HIST_BITS) ? MAX_PATTERN_BITS
                                                                     : HIST_BITS;
    localparam int LEN_W            = 7;
    localparam int SEEN_W           = 7;
    localparam int BYTE_W           = 8;
    localparam int WIN_W            = HIST_BITS - 1 + BYTE_W;

    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

    // configuration register indexes
    localparam logic REG_PATTERN_VALUE  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    typedef logic [HIST_BITS-1:0] word_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [SEEN_W-1:0]    seen_t;

    // zero length acts as one, long lengths clamp to the history size
    function automatic len_t eff_len(input len_t len);
        len_t res;
        res = len;
        if (res == '0)
            res = len_t'(1);
        if ({1'b0, res} > (LEN_W+1)'(LIMIT_BITS))
            res = len_t'(LIMIT_BITS);
        return res;
    endfunction

    function automatic word_t len_mask(input len_t len);
        word_t m;
        for (int i = 0; i < HIST_BITS; i++)
            m[i] = ((LEN_W+1)'(i) < {1'b0, len});
        return m;
    endfunction

endpackage

@@ rtl/core/bit_sequence_search.sv @@
// Top level of the bit sequence search block: stream ports, config port,
// history state and the two-stage result path. Depends on bss_pkg, bss_match.
//
// Usage:
//   The slave stream carries one byte per request (s_tdata, bit 7 first on
//   the line) with s_tlast marking the final byte of a stream. Every input
//   byte yields one result on the master stream: m_tdata[0] is the hit in
//   this byte, m_tdata[1] the sticky found flag, m_tlast echoes the input
//   marker; when it is set, m_tdata[1] is the answer for the whole stream.
//   The config channel writes index 0 (pattern value, right aligned) or
//   index 1 (pattern length, 1..64) and is always ready; write it only
//   while no request is in flight.
//   The accepting edge loads the input register, and the compare of all
//   eight end positions in the byte feeds the result register, which drives
//   m_tvalid. Throughput is one byte per cycle while the result stream is
//   not held by a low m_tready.
//   Reset clears history, bit count, found flag and pipeline valids, and
//   sets the pattern to zero with length one. The stream state also clears
//   after each byte marked last. When m_tready is low the result holds and
//   one more byte is taken into the input stage before s_tready drops.

module bit_sequence_search
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [0] hit_in_byte, [1] found_so_far, [7:2] zero
    output logic        m_tlast,     // stream_end
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    // configuration
    bss_pkg::word_t pattern_reg;
    bss_pkg::len_t  len_reg;
    bss_pkg::word_t mask_reg;
    bss_pkg::word_t want;
    bss_pkg::len_t  len_eff;

    // stream state
    bss_pkg::word_t hist_reg, hist_next;
    bss_pkg::seen_t seen_reg, seen_next;
    logic           found_reg, found_next;

    // input stage
    logic                            s1_valid_reg;
    logic [bss_pkg::HIST_BITS-2:0]   s1_hist_reg;
    bss_pkg::seen_t                  s1_seen_reg;
    logic [bss_pkg::BYTE_W-1:0]      s1_byte_reg;
    logic                            s1_last_reg;

    // result stage
    logic out_valid_reg;
    logic out_hit_reg;
    logic out_found_reg;
    logic out_last_reg;

    logic s_fire;
    logic s1_adv;
    logic hit;

    assign cfg_ready = 1'b1;
    assign len_eff   = bss_pkg::eff_len(len_reg);
    assign want      = pattern_reg & mask_reg;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            len_reg     <= bss_pkg::len_t'(1);
            mask_reg    <= bss_pkg::word_t'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bss_pkg::REG_PATTERN_VALUE:
                begin
                    pattern_reg <= cfg_data;
                end
                bss_pkg::REG_PATTERN_LENGTH:
                begin
                    len_reg  <= cfg_data[bss_pkg::LEN_W-1:0];
                    mask_reg <= bss_pkg::len_mask(bss_pkg::eff_len(cfg_data[bss_pkg::LEN_W-1:0]));
                end
                default:
                begin
                    pattern_reg <= pattern_reg;
                end
            endcase
        end
    end

    // history and bit count advance when the byte is accepted, and clear on a last byte
    always_comb
    begin
        hist_next = hist_reg;
        seen_next = seen_reg;
        if (s_fire)
        begin
            if (s_tlast)
            begin
                hist_next = '0;
                seen_next = '0;
            end
            else
            begin
                hist_next = {hist_reg[bss_pkg::HIST_BITS-bss_pkg::BYTE_W-1:0], s_tdata};
                if (seen_reg > (bss_pkg::SEEN_MAX - bss_pkg::seen_t'(bss_pkg::BYTE_W)))
                    seen_next = bss_pkg::SEEN_MAX;
                else
                    seen_next = seen_reg + bss_pkg::seen_t'(bss_pkg::BYTE_W);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            seen_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_hist_reg <= hist_reg[bss_pkg::HIST_BITS-2:0];
            s1_seen_reg <= seen_reg;
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
    end

    bss_match u_match
    (
        .window (bss_pkg::WIN_W'({s1_hist_reg, s1_byte_reg})),
        .seen   (s1_seen_reg),
        .len    (len_eff),
        .mask   (mask_reg),
        .want   (want),
        .hit    (hit)
    );

    // sticky flag follows results in order, cleared after the last byte
    always_comb
    begin
        found_next = found_reg;
        if (s1_adv)
            found_next = s1_last_reg ? 1'b0 : (found_reg || hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
            if (!out_valid_reg || m_tready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_hit_reg   <= hit;
            out_found_reg <= found_reg || hit;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_found_reg, out_hit_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/core/bss_match.sv @@
// Compares the pattern against the eight windows ending inside one byte.
// Depends on bss_pkg.

module bss_match
(
    input  logic [bss_pkg::WIN_W-1:0]  window,   // older history bits above, new byte low
    input  bss_pkg::seen_t             seen,     // bits seen before this byte
    input  bss_pkg::len_t              len,      // effective pattern length
    input  bss_pkg::word_t             mask,
    input  bss_pkg::word_t             want,
    output logic                       hit
);

    logic [bss_pkg::BYTE_W-1:0] pos_hit;

    always_comb
    begin
        for (int j = 1; j <= bss_pkg::BYTE_W; j++)
        begin
            // after j bits of the byte, the newest bit is byte bit 8-j
            pos_hit[j-1] = (({1'b0, seen} + (bss_pkg::SEEN_W+1)'(j)) >=
                            (bss_pkg::SEEN_W+1)'(len)) &&
                           ((window[(bss_pkg::BYTE_W-j) +: bss_pkg::HIST_BITS] & mask)
                            == want);
        end
    end

    assign hit = |pos_hit;

endmodule

@@ tb/bss_checker.sv @@
// Passive checker for bit_sequence_search: watches config, input and result channels,
// predicts each result from its own copy of pattern and stream state, and compares.
// Depends on bss_pkg for widths, types and register indexes.

module bss_checker
    import bss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,     // [0] hit_in_byte, [1] found_so_far, [7:2] zero
    input  logic        m_tlast,     // stream_end
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic hit;
        logic found;
        logic stream_end;
    } scan_result_t;

    word_t        pat_value;
    len_t         pat_length;
    word_t        history;
    seen_t        seen_bits;
    logic         found_flag;
    int           err_total;
    scan_result_t result_q[$];

    task automatic flag(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
        err_total++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        scan_result_t exp_r;
        word_t        mask;
        word_t        target;
        len_t         eff;
        logic         hit;
        if (!rst_n)
        begin
            pat_value   = '0;
            pat_length  = len_t'(1);
            history     = '0;
            seen_bits   = '0;
            found_flag  = 1'b0;
            err_total   = 0;
            result_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    err_total++;
                    $display("%0t: result with none expected: expected none, actual %0h last %0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (m_tdata[0] !== exp_r.hit)
                        flag("hit_in_byte", {7'b0, exp_r.hit}, {7'b0, m_tdata[0]});
                    if (m_tdata[1] !== exp_r.found)
                        flag("found_so_far", {7'b0, exp_r.found}, {7'b0, m_tdata[1]});
                    if (m_tlast !== exp_r.stream_end)
                        flag("stream_end", {7'b0, exp_r.stream_end}, {7'b0, m_tlast});
                    if (m_tdata[7:2] !== 6'b0)
                        flag("tdata padding", 8'h00, {2'b00, m_tdata[7:2]});
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PATTERN_VALUE)
                    pat_value = cfg_data;
                else
                    pat_length = cfg_data[LEN_W-1:0];
            end

            if (s_tvalid && s_tready)
            begin
                // zero length acts as one, anything past the history width clamps to it
                if (pat_length == '0)
                    eff = len_t'(1);
                else if (pat_length > len_t'(LIMIT_BITS))
                    eff = len_t'(LIMIT_BITS);
                else
                    eff = pat_length;
                for (int i = 0; i < HIST_BITS; i++)
                    mask[i] = (i < eff);
                target = pat_value & mask;
                hit = 1'b0;
                // bit 7 enters first; every shift is a possible match end
                for (int k = 7; k >= 0; k--)
                begin
                    history = {history[HIST_BITS-2:0], s_tdata[k]};
                    if (seen_bits != SEEN_MAX)
                        seen_bits = seen_bits + 1'b1;
                    if (seen_bits >= eff && (history & mask) == target)
                        hit = 1'b1;
                end
                found_flag = found_flag | hit;
                result_q.push_back({hit, found_flag, s_tlast});
                if (s_tlast)
                begin
                    history    = '0;
                    seen_bits  = '0;
                    found_flag = 1'b0;
                end
            end

            mismatches  <= err_total;
            outstanding <= result_q.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the bit_sequence_search testbench: clock, reset, stream and config stimulus,
// receiver backpressure, stall watchdog and verdict. Depends on bss_pkg,
// bit_sequence_search and bss_checker.

module tb;
    import bss_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 92;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_PATTERN_VALUE;
    logic [63:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int src_idle = 13;
    int dst_idle = 46;
    int quiet    = 0;

    always #10 clk = ~clk;

    bit_sequence_search u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bss_checker u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= dst_idle);

    // stall watchdog: no request on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // valid stays high from one byte to the next unless a gap is taken
    task automatic push_byte(input logic [7:0] d, input logic last);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_pattern(input word_t value, input len_t length);
        write_reg(REG_PATTERN_VALUE, value);
        write_reg(REG_PATTERN_LENGTH, {57'b0, length});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // one stream: pattern embedded in random bits, a near miss, or plain noise
    task automatic send_stream(input int elen, input word_t pat, output int nbytes);
        bit         bits_q[$];
        int         kind;
        int         reps;
        int         flip;
        logic [7:0] d;
        kind = $urandom_range(99);
        if (kind >= 80)
        begin
            repeat (8 * $urandom_range(1, 24))
                bits_q.push_back(bit'($urandom_range(1)));
        end
        else
        begin
            reps = (kind < 60) ? $urandom_range(1, 3) : 1;
            flip = (kind < 60) ? -1 : $urandom_range(0, elen - 1);
            repeat (reps)
            begin
                repeat ($urandom_range(0, 40))
                    bits_q.push_back(bit'($urandom_range(1)));
                for (int j = elen - 1; j >= 0; j--)
                    bits_q.push_back(pat[j] ^ (j == flip));
            end
            repeat ($urandom_range(0, 40))
                bits_q.push_back(bit'($urandom_range(1)));
            while (bits_q.size() % 8 != 0)
                bits_q.push_back(bit'($urandom_range(1)));
        end
        nbytes = bits_q.size() / 8;
        for (int i = 0; i < nbytes; i++)
        begin
            for (int b = 0; b < 8; b++)
                d[7-b] = bits_q[8*i+b];
            push_byte(d, i == nbytes - 1);
        end
    endtask

    initial
    begin : stimulus
        len_t  length;
        word_t pat;
        int    elen;
        int    sent;
        int    n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one-bit pattern of zero
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();
        // zero length acts as one
        set_pattern(64'h1, 7'd0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        wait_idle();
        // overlong length clamps to 64; no hit before 64 bits; hits go on after the find
        set_pattern('1, 7'd127);
        repeat (9)
            push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();
        // pattern across a byte boundary; upper pattern bits ignored
        set_pattern(64'hFFFF_FFFF_FFFF_FABC, 7'd12);
        push_byte(8'h0A, 1'b0);
        push_byte(8'hBC, 1'b1);
        wait_idle();
        // all-zero 64-bit pattern over cleared history: only the 64th bit may hit
        set_pattern('0, 7'd64);
        for (int i = 0; i < 8; i++)
            push_byte(8'h00, i == 7);

        for (int regime = 0; regime < 3; regime++)
        begin
            src_idle = (regime == 0) ? 13 : (regime == 1) ? 46 : 0;
            dst_idle = (regime == 0) ? 46 : (regime == 1) ? 13 : 0;
            for (int step = 0; step < 6; step++)
            begin
                wait_idle();
                case (step)
                    0:       length = len_t'(1);
                    1:       length = len_t'(64);
                    2:       length = len_t'(0);
                    3:       length = len_t'($urandom_range(65, 127));
                    default: length = len_t'($urandom_range(2, 63));
                endcase
                pat = {$urandom, $urandom};
                if ($urandom_range(5) == 0)
                    pat = '0;
                else if ($urandom_range(5) == 0)
                    pat = '1;
                set_pattern(pat, length);
                elen = (length == 0) ? 1 : (length > 64) ? 64 : int'(length);
                sent = 0;
                while (sent < PHASE_BYTES)
                begin
                    send_stream(elen, pat, n);
                    sent += n;
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
